// ----- rtl/sesm_pkg.sv -----
package sesm_pkg;

    // Field widths
    localparam int unsigned ALPHA_W  = 16;
    localparam int unsigned TEMP_W   = 16;
    localparam int unsigned HUM_W    = 16;
    localparam int unsigned LIGHT_W  = 32;
    localparam int unsigned SMOKE_W  = 16;

    // Packing of the data bus, lowest field first
    localparam int unsigned TEMP_LSB  = 0;
    localparam int unsigned HUM_LSB   = TEMP_LSB + TEMP_W;
    localparam int unsigned LIGHT_LSB = HUM_LSB + HUM_W;
    localparam int unsigned SMOKE_LSB = LIGHT_LSB + LIGHT_W;
    localparam int unsigned DATA_W    = SMOKE_LSB + SMOKE_W;

    // Input flag positions in tuser
    localparam int unsigned IN_USER_W   = 2;
    localparam int unsigned USER_CMD    = 0;
    localparam int unsigned USER_SVALID = 1;

    // Configuration port
    localparam int unsigned CFG_ADDR_W = 8;
    localparam logic [CFG_ADDR_W-1:0] REG_ALPHA_NUM = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ALPHA_DEN = 8'd1;
    localparam logic [ALPHA_W-1:0] ALPHA_NUM_RST = 16'd1;
    localparam logic [ALPHA_W-1:0] ALPHA_DEN_RST = 16'd8;

    // Serial step counter: the widest channel sets the length
    localparam int unsigned CNT_W = $clog2(LIGHT_W + 1);

    // Result status codes
    typedef enum logic [1:0] {
        ST_ACCEPT = 2'd0,
        ST_REJECT = 2'd1,
        ST_CLEAR  = 2'd2
    } t_status;

    // Controls from the sequencer to each scaler lane
    typedef struct packed {
        logic load;
        logic step;
    } t_lane_ctl;

endpackage

// ----- rtl/sesm_lane.sv -----
// Bit-serial scaler: o_quo = floor(mag * num / den), one magnitude bit per
// step, MSB first. Remainder stays below den, so each step yields a
// quotient digit of 0, 1 or 2 (num never exceeds den on this path).
module sesm_lane #(
    parameter int unsigned MAG_W = 16
) (
    input  logic                          i_clk,
    input  sesm_pkg::t_lane_ctl           i_ctl,
    input  logic [sesm_pkg::ALPHA_W-1:0]  i_num,
    input  logic [sesm_pkg::ALPHA_W-1:0]  i_den,
    input  logic [MAG_W-1:0]              i_mag,
    output logic [MAG_W-1:0]              o_quo
);
    import sesm_pkg::*;

    logic [MAG_W-1:0]   r_mag;
    logic [ALPHA_W-1:0] r_rem;
    logic [MAG_W-1:0]   r_quo;

    logic [ALPHA_W+1:0] w_sum;
    logic [ALPHA_W+1:0] w_den1;
    logic [ALPHA_W+1:0] w_den2;
    logic [ALPHA_W+1:0] w_rest;
    logic [1:0]         w_dig;
    logic [ALPHA_W-1:0] n_rem;
    logic [MAG_W-1:0]   n_quo;

    // Horner step: rem = 2*rem + bit*num, then reduce by den or 2*den
    always_comb begin
        w_den1 = {2'b00, i_den};
        w_den2 = {1'b0, i_den, 1'b0};
        w_sum  = {1'b0, r_rem, 1'b0} + (r_mag[MAG_W-1] ? {2'b00, i_num} : '0);
        priority if (w_sum >= w_den2) begin
            w_rest = w_sum - w_den2;
            w_dig  = 2'd2;
        end else if (w_sum >= w_den1) begin
            w_rest = w_sum - w_den1;
            w_dig  = 2'd1;
        end else begin
            w_rest = w_sum;
            w_dig  = 2'd0;
        end
        n_rem = w_rest[ALPHA_W-1:0];
        n_quo = {r_quo[MAG_W-2:0], 1'b0} + MAG_W'(w_dig);
    end

    // Datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_mag <= i_mag;
            r_rem <= '0;
            r_quo <= '0;
        end else if (i_ctl.step) begin
            r_mag <= {r_mag[MAG_W-2:0], 1'b0};
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_quo = r_quo;

endmodule

// ----- rtl/sensor_exponential_smoother.sv -----
// Four-channel exponential smoother (temperature, humidity, light, smoke).
// A filtered sample with history: on acceptance the magnitudes are formed and
// loaded into the bit-serial scalers, 32 serial steps follow (one magnitude
// bit per cycle; the 32-bit light channel sets the length, the 16-bit
// channels run in parallel and finish early), then the held values are
// updated and the output register is loaded once it is free. Restart, rejected
// samples and the first sample after restart go straight to the output
// register. The result sits there, so the next word is accepted while a
// result waits downstream. Configure alpha only while the block is idle.
module sensor_exponential_smoother (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sesm_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [sesm_pkg::ALPHA_W-1:0]        i_cfg_data,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: temperature_in[15:0], humidity_in[31:16], light_in[63:32], smoke_in[79:64]
    input  logic [sesm_pkg::DATA_W-1:0]         s_axis_tdata,
    // tuser: command[0], sample_valid[1]
    input  logic [sesm_pkg::IN_USER_W-1:0]      s_axis_tuser,
    // output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: temperature_out[15:0], humidity_out[31:16], light_out[63:32], smoke_out[79:64]
    output logic [sesm_pkg::DATA_W-1:0]         m_axis_tdata,
    // tuser: status[1:0]
    output logic [1:0]                          m_axis_tuser
);
    import sesm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CALC = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_primed, n_primed;
    logic [ALPHA_W-1:0] r_alpha_num, n_alpha_num;
    logic [ALPHA_W-1:0] r_alpha_den, n_alpha_den;
    t_status            r_status, n_status;
    logic [3:0]         r_neg, n_neg;
    logic [TEMP_W-1:0]  r_held_t, n_held_t;
    logic [HUM_W-1:0]   r_held_h, n_held_h;
    logic [LIGHT_W-1:0] r_held_l, n_held_l;
    logic [SMOKE_W-1:0] r_held_s, n_held_s;
    logic               r_out_valid, n_out_valid;
    t_status            r_out_status, n_out_status;
    logic [DATA_W-1:0]  r_out_data, n_out_data;

    logic               w_accept;
    logic               w_cfg_we;
    logic               w_cmd;
    logic               w_svalid;
    logic               w_bad;
    logic [TEMP_W-1:0]  w_t_in;
    logic [HUM_W-1:0]   w_h_in;
    logic [LIGHT_W-1:0] w_l_in;
    logic [SMOKE_W-1:0] w_s_in;
    logic [TEMP_W:0]    w_dt, w_at;
    logic [HUM_W:0]     w_dh, w_ah;
    logic [LIGHT_W:0]   w_dl, w_al;
    logic [SMOKE_W:0]   w_ds, w_as;
    logic [TEMP_W-1:0]  w_q_t;
    logic [HUM_W-1:0]   w_q_h;
    logic [LIGHT_W-1:0] w_q_l;
    logic [SMOKE_W-1:0] w_q_s;
    logic               w_out_free;
    t_lane_ctl          w_ctl_t, w_ctl_h, w_ctl_l, w_ctl_s;

    // Handshakes
    assign o_cfg_ready   = 1'b1;
    assign w_cfg_we      = i_cfg_valid & o_cfg_ready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid & s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    // Field extraction
    assign w_cmd    = s_axis_tuser[USER_CMD];
    assign w_svalid = s_axis_tuser[USER_SVALID];
    assign w_t_in   = s_axis_tdata[TEMP_LSB  +: TEMP_W];
    assign w_h_in   = s_axis_tdata[HUM_LSB   +: HUM_W];
    assign w_l_in   = s_axis_tdata[LIGHT_LSB +: LIGHT_W];
    assign w_s_in   = s_axis_tdata[SMOKE_LSB +: SMOKE_W];

    assign w_bad = (r_alpha_den == '0) || (r_alpha_num == '0) || (r_alpha_num > r_alpha_den);

    // Change from held value; sign bit gives direction, magnitude goes to lanes
    always_comb begin
        w_dt = {w_t_in[TEMP_W-1], w_t_in} - {r_held_t[TEMP_W-1], r_held_t};
        w_dh = {1'b0, w_h_in} - {1'b0, r_held_h};
        w_dl = {1'b0, w_l_in} - {1'b0, r_held_l};
        w_ds = {1'b0, w_s_in} - {1'b0, r_held_s};
        w_at = w_dt[TEMP_W]  ? ('0 - w_dt) : w_dt;
        w_ah = w_dh[HUM_W]   ? ('0 - w_dh) : w_dh;
        w_al = w_dl[LIGHT_W] ? ('0 - w_dl) : w_dl;
        w_as = w_ds[SMOKE_W] ? ('0 - w_ds) : w_ds;
    end

    // Lane controls: load on a filtered, primed sample; each lane steps its width
    always_comb begin
        logic w_load;
        w_load       = w_accept && !w_cmd && w_svalid && !w_bad && r_primed;
        w_ctl_t.load = w_load;
        w_ctl_h.load = w_load;
        w_ctl_l.load = w_load;
        w_ctl_s.load = w_load;
        w_ctl_t.step = (r_state == S_CALC) && (r_cnt < CNT_W'(TEMP_W));
        w_ctl_h.step = (r_state == S_CALC) && (r_cnt < CNT_W'(HUM_W));
        w_ctl_l.step = (r_state == S_CALC) && (r_cnt < CNT_W'(LIGHT_W));
        w_ctl_s.step = (r_state == S_CALC) && (r_cnt < CNT_W'(SMOKE_W));
    end

    sesm_lane #(.MAG_W(TEMP_W)) u_lane_t (
        .i_clk(i_clk), .i_ctl(w_ctl_t), .i_num(r_alpha_num), .i_den(r_alpha_den),
        .i_mag(w_at[TEMP_W-1:0]), .o_quo(w_q_t)
    );
    sesm_lane #(.MAG_W(HUM_W)) u_lane_h (
        .i_clk(i_clk), .i_ctl(w_ctl_h), .i_num(r_alpha_num), .i_den(r_alpha_den),
        .i_mag(w_ah[HUM_W-1:0]), .o_quo(w_q_h)
    );
    sesm_lane #(.MAG_W(LIGHT_W)) u_lane_l (
        .i_clk(i_clk), .i_ctl(w_ctl_l), .i_num(r_alpha_num), .i_den(r_alpha_den),
        .i_mag(w_al[LIGHT_W-1:0]), .o_quo(w_q_l)
    );
    sesm_lane #(.MAG_W(SMOKE_W)) u_lane_s (
        .i_clk(i_clk), .i_ctl(w_ctl_s), .i_num(r_alpha_num), .i_den(r_alpha_den),
        .i_mag(w_as[SMOKE_W-1:0]), .o_quo(w_q_s)
    );

    // Sequencer and state update
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_primed     = r_primed;
        n_alpha_num  = r_alpha_num;
        n_alpha_den  = r_alpha_den;
        n_status     = r_status;
        n_neg        = r_neg;
        n_held_t     = r_held_t;
        n_held_h     = r_held_h;
        n_held_l     = r_held_l;
        n_held_s     = r_held_s;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_status = r_out_status;
        n_out_data   = r_out_data;

        // config writes; indexes beyond the list are dropped
        if (w_cfg_we) begin
            if (i_cfg_addr == REG_ALPHA_NUM) begin
                n_alpha_num = i_cfg_data;
            end else if (i_cfg_addr == REG_ALPHA_DEN) begin
                n_alpha_den = i_cfg_data;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cnt = '0;
                    priority if (w_cmd) begin
                        n_primed = 1'b0;
                        n_status = ST_CLEAR;
                        n_state  = S_EMIT;
                    end else if (!w_svalid || w_bad) begin
                        n_status = ST_REJECT;
                        n_state  = S_EMIT;
                    end else if (!r_primed) begin
                        // first sample primes the store
                        n_primed = 1'b1;
                        n_held_t = w_t_in;
                        n_held_h = w_h_in;
                        n_held_l = w_l_in;
                        n_held_s = w_s_in;
                        n_status = ST_ACCEPT;
                        n_state  = S_EMIT;
                    end else begin
                        n_neg    = {w_ds[SMOKE_W], w_dl[LIGHT_W], w_dh[HUM_W], w_dt[TEMP_W]};
                        n_status = ST_ACCEPT;
                        n_state  = S_CALC;
                    end
                end
            end
            S_CALC: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(LIGHT_W)) begin
                    // scaled steps are in; move toward the samples
                    n_held_t = r_neg[0] ? r_held_t - w_q_t : r_held_t + w_q_t;
                    n_held_h = r_neg[1] ? r_held_h - w_q_h : r_held_h + w_q_h;
                    n_held_l = r_neg[2] ? r_held_l - w_q_l : r_held_l + w_q_l;
                    n_held_s = r_neg[3] ? r_held_s - w_q_s : r_held_s + w_q_s;
                    n_state  = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_data   = (r_status == ST_ACCEPT) ?
                                   {r_held_s, r_held_l, r_held_h, r_held_t} : '0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_primed    <= 1'b0;
            r_alpha_num <= ALPHA_NUM_RST;
            r_alpha_den <= ALPHA_DEN_RST;
            r_held_t    <= '0;
            r_held_h    <= '0;
            r_held_l    <= '0;
            r_held_s    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_primed    <= n_primed;
            r_alpha_num <= n_alpha_num;
            r_alpha_den <= n_alpha_den;
            r_held_t    <= n_held_t;
            r_held_h    <= n_held_h;
            r_held_l    <= n_held_l;
            r_held_s    <= n_held_s;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_status     <= n_status;
        r_neg        <= n_neg;
        r_out_status <= n_out_status;
        r_out_data   <= n_out_data;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_status;

    // Restart clears history on the next edge
    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_cmd) |=> (!r_primed && r_status == ST_CLEAR))
        else $error("restart did not clear primed flag");

    // Bad weight rejects without touching history
    a_bad_weight_rejects: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_cmd && w_bad) |=>
            (r_state == S_EMIT && r_status == ST_REJECT && $stable(r_held_l)))
        else $error("bad weight sample was not rejected");

    // First sample after restart passes straight into the store
    a_prime_passthrough: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_cmd && w_svalid && !w_bad && !r_primed) |=>
            (r_primed && r_held_l == $past(w_l_in) && r_held_t == $past(w_t_in)))
        else $error("priming sample not stored");

    // Serial pass ends after the widest lane and hands off to the output stage
    a_calc_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CALC && r_cnt == CNT_W'(LIGHT_W)) |=> (r_state == S_EMIT))
        else $error("scaler pass length wrong");

endmodule
